[hw/rtl/ddpi_pkg.sv]
`default_nettype none
package ddpi_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 24;
	localparam int ATAN_COUNT = 30;
	localparam int CORD_W = 34;
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_START_X = 2'd1;
	localparam logic [1:0] REG_START_Y = 2'd2;
	localparam logic [1:0] REG_START_HEADING = 2'd3;

	typedef struct packed {
		logic command;
		logic signed [23:0] speed;
		logic signed [31:0] turn_rate;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0] heading;
	} pose_t;

	typedef struct packed {
		logic busy;
		logic signed [CORD_W-1:0] cos_v;
		logic signed [CORD_W-1:0] sin_v;
	} cordic_st_t;

	// arctangent of 2^-i as a binary angle
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/diff_drive_pose_integrator.sv]
// Differential-drive pose integrator, Euler dead reckoning in fixed point.
// Request channel (req_valid, req_stall, req): command 0 reloads the pose from
// the start registers, command 1 moves x and y by time_step*speed along the
// current heading, then advances the heading by time_step*turn_rate.
// Response channel (rsp_valid, rsp_stall, rsp): one pose per request.
// Configuration goes through the APB port: time_step at 0x0, start_x at 0x4,
// start_y at 0x8, start_heading at 0xC; write only while the block is idle.
// A step request runs the CORDIC unit, which does one iteration per cycle,
// followed by the two position multiplies on the shared multiplier.
// One request is in flight at a time: req_stall is high from accept until
// the response is written to the output register.
// The output register frees the request side; if a response is still stalled
// when the next one is ready, the sequencer holds until it is taken.
// Reset clears the pose to zero, loads the register defaults and drops
// rsp_valid.
`default_nettype none
module diff_drive_pose_integrator #(
	parameter int CORDIC_ITERATIONS = ddpi_pkg::CORDIC_ITERATIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic req_valid,
	output logic req_stall,
	input wire ddpi_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output ddpi_pkg::pose_t rsp
);
	import ddpi_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MD = 3'd1;
	localparam logic [2:0] S_MH = 3'd2;
	localparam logic [2:0] S_DH = 3'd3;
	localparam logic [2:0] S_CWAIT = 3'd4;
	localparam logic [2:0] S_MX = 3'd5;
	localparam logic [2:0] S_MY = 3'd6;
	localparam logic [2:0] S_WB = 3'd7;

	localparam logic signed [PROD_W-1:0] HALF38 = {{(PROD_W-38){1'b0}}, 1'b1, 37'd0};
	localparam logic signed [PROD_W-1:0] HALF24 = {{(PROD_W-24){1'b0}}, 1'b1, 23'd0};

	logic [2:0] state_q;
	logic [23:0] dt_q;
	logic [31:0] sx_q, sy_q, sh_q;
	logic [31:0] x_q, y_q, h_q;
	req_t req_q;
	logic signed [32:0] d_q;
	logic [31:0] dh_q, dx_q;
	logic rsp_valid_q;
	pose_t rsp_q;

	logic acc, wr, slot_free;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [PROD_W-1:0] prod_q, rnd38, rnd24, shr16;
	cordic_st_t cor;

	assign acc = req_valid && !req_stall;
	assign wr = psel && penable && pwrite && pready;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign pready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_TIME_STEP: prdata = {8'd0, dt_q};
			REG_START_X: prdata = sx_q;
			REG_START_Y: prdata = sy_q;
			REG_START_HEADING: prdata = sh_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 24'd335544;
			sx_q <= '0;
			sy_q <= '0;
			sh_q <= '0;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_TIME_STEP: dt_q <= pwdata[23:0];
				REG_START_X: sx_q <= pwdata;
				REG_START_Y: sy_q <= pwdata;
				REG_START_HEADING: sh_q <= pwdata;
				default: ;
			endcase
		end
	end

	// shared multiplier operands, chosen by sequencer state
	always_comb begin
		unique case (state_q)
			S_MD: begin
				ma = {{(MUL_W-24){1'b0}}, dt_q};
				mb = {{(MUL_W-24){req_q.speed[23]}}, req_q.speed};
			end
			S_MH: begin
				ma = {{(MUL_W-24){1'b0}}, dt_q};
				mb = {{(MUL_W-32){req_q.turn_rate[31]}}, req_q.turn_rate};
			end
			S_MX: begin
				ma = {{(MUL_W-33){d_q[32]}}, d_q};
				mb = cor.cos_v;
			end
			default: begin
				ma = {{(MUL_W-33){d_q[32]}}, d_q};
				mb = cor.sin_v;
			end
		endcase
	end

	ddpi_mul u_mul (
		.clk(clk),
		.a(ma),
		.b(mb),
		.p_q(prod_q)
	);

	ddpi_cordic #(
		.ITERATIONS(CORDIC_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(acc && req.command == CMD_STEP),
		.angle(h_q),
		.status(cor)
	);

	assign shr16 = prod_q >>> 16;
	assign rnd38 = (prod_q + HALF38) >>> 38;
	assign rnd24 = (prod_q + HALF24) >>> 24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			h_q <= '0;
		end else begin
			if (state_q == S_WB && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= (req.command == CMD_STEP) ? S_MD : S_WB;
					end
				end
				S_MD: state_q <= S_MH;
				S_MH: state_q <= S_DH;
				S_DH: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (!cor.busy) begin
						state_q <= S_MX;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_WB;
				S_WB: begin
					// hold until the output register is free
					if (slot_free) begin
						if (req_q.command == CMD_STEP) begin
							x_q <= x_q + dx_q;
							y_q <= y_q + rnd38[31:0];
							h_q <= h_q + dh_q;
						end else begin
							x_q <= sx_q;
							y_q <= sy_q;
							h_q <= sh_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req;
		end
		if (state_q == S_MH) begin
			d_q <= shr16[32:0];
		end
		if (state_q == S_DH) begin
			dh_q <= rnd24[31:0];
		end
		if (state_q == S_MY) begin
			dx_q <= rnd38[31:0];
		end
		if (state_q == S_WB && slot_free) begin
			if (req_q.command == CMD_STEP) begin
				rsp_q.pos_x <= x_q + dx_q;
				rsp_q.pos_y <= y_q + rnd38[31:0];
				rsp_q.heading <= h_q + dh_q;
			end else begin
				rsp_q.pos_x <= sx_q;
				rsp_q.pos_y <= sy_q;
				rsp_q.heading <= sh_q;
			end
		end
	end

	a_step_starts_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.command == CMD_STEP) |=> cor.busy)
		else $error("step request did not start the CORDIC unit");

	a_pose_only_at_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WB) |=> ($stable(x_q) && $stable(y_q) && $stable(h_q)))
		else $error("pose changed outside write-back");

	a_rsp_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_WB)
		else $error("response raised outside write-back");

	a_cordic_done_before_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MX || state_q == S_MY) |-> !cor.busy)
		else $error("position multiply used CORDIC result while busy");

endmodule
`default_nettype wire

[hw/rtl/ddpi_mul.sv]
`default_nettype none
module ddpi_mul (
	input wire logic clk,
	input wire logic signed [ddpi_pkg::MUL_W-1:0] a,
	input wire logic signed [ddpi_pkg::MUL_W-1:0] b,
	output logic signed [ddpi_pkg::PROD_W-1:0] p_q
);
	import ddpi_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

[hw/rtl/ddpi_cordic.sv]
`default_nettype none
module ddpi_cordic #(
	parameter int ITERATIONS = ddpi_pkg::CORDIC_ITERATIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] angle,
	output ddpi_pkg::cordic_st_t status
);
	import ddpi_pkg::*;

	localparam int NITER = (ITERATIONS < ATAN_COUNT) ? ITERATIONS : ATAN_COUNT;
	localparam int CNT_W = $clog2(NITER);
	localparam logic signed [CORD_W-1:0] QUARTER = CORD_W'(34'sd1073741824);
	localparam logic signed [CORD_W-1:0] HALF = CORD_W'(34'sd2147483648);

	logic run_q;
	logic flip_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [CORD_W-1:0] xs, ys, atn, za;

	assign za = {{(CORD_W-32){angle[31]}}, angle};
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign atn = {{(CORD_W-32){1'b0}}, atan_turn(5'(cnt_q))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NITER - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= {{(CORD_W-32){1'b0}}, CORDIC_GAIN_Q30};
			y_q <= '0;
			// fold the angle into the right half plane, negate the result later
			if (za > QUARTER) begin
				z_q <= za - HALF;
				flip_q <= 1'b1;
			end else if (za < -QUARTER) begin
				z_q <= za + HALF;
				flip_q <= 1'b1;
			end else begin
				z_q <= za;
				flip_q <= 1'b0;
			end
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
		end
	end

	assign status.busy = run_q;
	assign status.cos_v = flip_q ? -x_q : x_q;
	assign status.sin_v = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

[verif/ddpi_pose_checker.sv]
module ddpi_pose_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic pready,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire ddpi_pkg::req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire ddpi_pkg::pose_t rsp,
	output int fail_count,
	output int pending
);
	import ddpi_pkg::*;

	localparam int ITERATIONS = CORDIC_ITERATIONS_DEF;
	localparam longint QUARTER_TURN = 64'sh4000_0000;
	localparam longint HALF_TURN = 64'sh8000_0000;
	localparam longint ROUND_38 = 64'sd1 <<< 37;
	localparam longint ROUND_24 = 64'sd1 <<< 23;
	localparam logic [31:0] ARCTAN_TURNS [30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	logic [23:0] time_step;
	logic [31:0] start_x;
	logic [31:0] start_y;
	logic [31:0] start_heading;
	pose_t pose;
	pose_t expected_poses[$];
	int mismatches = 0;

	// cosine and sine of a binary angle, Q2.30, by rotation-mode CORDIC
	function automatic void rotate_unit(input logic [31:0] angle, output longint c,
			output longint s);
		longint z, xv, yv, xs, ys;
		logic flip;
		int i;
		z = longint'($signed(angle));
		xv = longint'(CORDIC_GAIN_Q30);
		yv = 0;
		flip = 1'b0;
		// fold the back half-plane onto the front one and negate at the end
		if (z > QUARTER_TURN) begin
			z = z - HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z = z + HALF_TURN;
			flip = 1'b1;
		end
		for (i = 0; i < ITERATIONS && i < ATAN_COUNT; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (z >= 0) begin
				xv = xv - ys;
				yv = yv + xs;
				z = z - longint'(ARCTAN_TURNS[i]);
			end else begin
				xv = xv + ys;
				yv = yv - xs;
				z = z + longint'(ARCTAN_TURNS[i]);
			end
		end
		c = flip ? -xv : xv;
		s = flip ? -yv : yv;
	endfunction

	function automatic pose_t euler_advance(input pose_t cur, input req_t r,
			input logic [23:0] dt_q24);
		longint dt, v, w, d, c, s, dx, dy, dh;
		pose_t nxt;
		dt = longint'(dt_q24);
		v = longint'($signed(r.speed));
		w = longint'($signed(r.turn_rate));
		d = (dt * v) >>> 16;
		// position moves along the old heading
		rotate_unit(cur.heading, c, s);
		dx = (d * c + ROUND_38) >>> 38;
		dy = (d * s + ROUND_38) >>> 38;
		dh = (dt * w + ROUND_24) >>> 24;
		nxt.pos_x = cur.pos_x + dx[31:0];
		nxt.pos_y = cur.pos_y + dy[31:0];
		nxt.heading = cur.heading + dh[31:0];
		return nxt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		logic [31:0] held;
		if (!arst_n) begin
			time_step = 24'd335544;
			start_x = '0;
			start_y = '0;
			start_heading = '0;
			pose = '0;
			expected_poses.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_TIME_STEP: time_step = pwdata[23:0];
						REG_START_X: start_x = pwdata;
						REG_START_Y: start_y = pwdata;
						REG_START_HEADING: start_heading = pwdata;
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_TIME_STEP: held = {8'd0, time_step};
						REG_START_X: held = start_x;
						REG_START_Y: held = start_y;
						default: held = start_heading;
					endcase
					if (prdata !== held) begin
						$error("prdata: expected %h, got %h", held, prdata);
						mismatches += 1;
					end
				end
			end

			if (rsp_valid && !rsp_stall) begin
				if (expected_poses.size() == 0) begin
					$error("pose response with none pending: %h", rsp);
					mismatches += 1;
				end else begin
					want = expected_poses.pop_front();
					if (rsp.pos_x !== want.pos_x) begin
						$error("pos_x: expected %h, got %h", want.pos_x, rsp.pos_x);
						mismatches += 1;
					end
					if (rsp.pos_y !== want.pos_y) begin
						$error("pos_y: expected %h, got %h", want.pos_y, rsp.pos_y);
						mismatches += 1;
					end
					if (rsp.heading !== want.heading) begin
						$error("heading: expected %h, got %h", want.heading, rsp.heading);
						mismatches += 1;
					end
				end
			end

			if (req_valid && !req_stall) begin
				if (req.command == CMD_RESTART) begin
					pose.pos_x = start_x;
					pose.pos_y = start_y;
					pose.heading = start_heading;
				end else begin
					pose = euler_advance(pose, req, time_step);
				end
				expected_poses.insert(expected_poses.size(), pose);
			end
		end
		fail_count <= mismatches;
		pending <= expected_poses.size();
	end

endmodule

[verif/tb.sv]
module tb;
	import ddpi_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASES = 8;
	localparam int STEADY_PHASE = 3;
	localparam logic [31:0] EDGE_HEADINGS [5] = '{
		32'hC0000000, 32'h80000000, 32'h40000001, 32'hBFFFFFFF, 32'hFFFFFFFF
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	pose_t rsp;
	logic steady = 1'b0;
	int fail_count;
	int pending;
	int cycles = 0;

	always #5 clk = ~clk;

	diff_drive_pose_integrator dut (.*);

	ddpi_pose_checker pose_check (.*);

	always @(posedge clk) begin
		rsp_stall <= !steady && ($urandom_range(99) < 11);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic req_t make_req(input logic cmd, input logic [23:0] speed,
			input logic [31:0] turn);
		req_t r;
		r.command = cmd;
		r.speed = speed;
		r.turn_rate = turn;
		return r;
	endfunction

	task automatic send_request(input req_t item);
		while (!steady && ($urandom_range(99) < 11)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	// drop valid and wait for every pose to come back
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [23:0] ts, input logic [31:0] sx,
			input logic [31:0] sy, input logic [31:0] sh);
		apb_access(1'b1, REG_TIME_STEP, {8'd0, ts});
		apb_access(1'b1, REG_START_X, sx);
		apb_access(1'b1, REG_START_Y, sy);
		apb_access(1'b1, REG_START_HEADING, sh);
		apb_access(1'b0, REG_TIME_STEP, '0);
		apb_access(1'b0, REG_START_X, '0);
		apb_access(1'b0, REG_START_Y, '0);
		apb_access(1'b0, REG_START_HEADING, '0);
	endtask

	function automatic logic [23:0] pick_speed();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($signed($urandom_range(512)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_turn();
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(65536)) - 32768);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [23:0] ts;
		logic [31:0] sx, sy;
		int p, k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults, pose from zero; restart ignores speed and turn rate
		send_request(make_req(CMD_RESTART, 24'h7FFFFF, 32'h80000000));
		send_request(make_req(CMD_STEP, 24'h000000, 32'h00000000));
		send_request(make_req(CMD_STEP, 24'h7FFFFF, 32'h7FFFFFFF));
		send_request(make_req(CMD_STEP, 24'h800000, 32'h80000000));
		send_request(make_req(CMD_STEP, 24'hFFFFFF, 32'hFFFFFFFF));
		send_request(make_req(CMD_STEP, 24'h000001, 32'h00000001));
		settle();

		// largest step from the position extremes, heading a quarter turn
		load_config(24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h40000000);
		send_request(make_req(CMD_RESTART, 24'h000000, 32'h00000000));
		send_request(make_req(CMD_STEP, 24'h7FFFFF, 32'h00000000));
		send_request(make_req(CMD_STEP, 24'h800000, 32'h7FFFFFFF));
		settle();

		// headings on and around the fold boundaries, with position wrap
		for (k = 0; k < 5; k++) begin
			apb_access(1'b1, REG_START_HEADING, EDGE_HEADINGS[k]);
			send_request(make_req(CMD_RESTART, 24'($urandom), $urandom));
			send_request(make_req(CMD_STEP, 24'h7FFFFF, 32'h00000000));
			settle();
		end

		for (p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				ts = 24'h000000;
				sx = 32'h80000000;
				sy = 32'h7FFFFFFF;
			end else if (p == 1) begin
				ts = 24'hFFFFFF;
				sx = 32'h7FFFFFFF;
				sy = 32'h80000000;
			end else begin
				case ($urandom_range(3))
					0: ts = 24'hFFFFFF;
					1: ts = 24'($urandom_range(4095, 1));
					2: ts = 24'd335544;
					default: ts = 24'($urandom);
				endcase
				sx = $urandom;
				sy = $urandom;
			end
			load_config(ts, sx, sy, $urandom);
			steady <= (p == STEADY_PHASE);
			send_request(make_req(CMD_RESTART, pick_speed(), pick_turn()));
			for (k = 1; k < RANDOM_ITEMS / PHASES; k++) begin
				if ($urandom_range(9) == 0)
					send_request(make_req(CMD_RESTART, pick_speed(), pick_turn()));
				else
					send_request(make_req(CMD_STEP, pick_speed(), pick_turn()));
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
